@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) `ASSERT_PROP(lbl, !(expr))
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ hw/rtl/kcef_pkg.sv @@
// ---------------------------------------------------------------------------
// kcef_pkg
// shared types and constants of the keypad click event detector
// ---------------------------------------------------------------------------
package kcef_pkg;

	localparam int ROWS   = 8;
	localparam int COLS   = 16;
	localparam int NKEYS  = ROWS * COLS;
	localparam int KEY_W  = 7;
	localparam int NSLOTS = (NKEYS < (1 << KEY_W)) ? NKEYS : (1 << KEY_W);
	localparam int KEY_AW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	localparam int CFG_W    = 16;
	localparam int CFG_IW   = 2;
	localparam int IN_TW    = 40;
	localparam int OUT_TW   = 40;
	localparam int OUT_UW   = 2;

	localparam logic [CFG_IW-1:0] CFG_HOLD   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_DOUBLE = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_LONG   = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_DBL_EN = 2'd3;

	localparam logic [15:0] HOLD_RST   = 16'd100;
	localparam logic [15:0] DOUBLE_RST = 16'd300;
	localparam logic [15:0] LONG_RST   = 16'd1000;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PRESSED  = 2'd1;
	localparam logic [1:0] PH_HOLD     = 2'd2;
	localparam logic [1:0] PH_RELEASED = 2'd3;

	localparam int FL_PRESSED = 0;
	localparam int FL_LONGREL = 1;
	localparam int FL_DOUBLE  = 2;
	localparam int FL_SHORT   = 3;

	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_LONGREL = 2'd2;
	localparam logic [1:0] EV_DOUBLE  = 2'd3;

	typedef struct packed {
		logic [31:0]      now;
		logic             level;
		logic [KEY_W-1:0] key;
	} kcef_item_t;

	typedef struct packed {
		logic [31:0] fps;
		logic [31:0] ps;
		logic [3:0]  flags;
		logic [1:0]  phase;
	} kcef_entry_t;

	typedef struct packed {
		logic [31:0] held;
		logic [1:0]  kind;
	} kcef_event_t;

	typedef struct packed {
		logic avail;
		logic pop;
	} kcef_qctl_t;

endpackage

@@ hw/rtl/keypad_click_event_fsm.sv @@
// ---------------------------------------------------------------------------
// keypad_click_event_fsm
// press, release, long release and double press events for matrix keys
//
//   port group   dir  beat contents
//   s_*          in   key_index, key_level, now_ms
//   m_*          out  event_key, held_ms; tuser event_kind; tlast on final event
//   cfg_*        in   hold_ms, double_ms, long_ms, double_enable writes
//
// an item passes through the state machine in order: key entry read, then
// update and write back; its events then leave as beats on the output
// a two-beat input queue takes beats until full while events wait on m_tready
// the next key entry read waits until every event of the last item is taken
// reset clears key state at once through per-key valid flags, no sweep
// ---------------------------------------------------------------------------
module keypad_click_event_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [kcef_pkg::IN_TW-1:0]  s_tdata,   // key_index[6:0], key_level[7], now_ms[39:8]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [kcef_pkg::OUT_TW-1:0] m_tdata,   // event_key[6:0], held_ms[38:7]
	output logic [kcef_pkg::OUT_UW-1:0] m_tuser,   // event_kind[1:0]
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [kcef_pkg::CFG_IW-1:0] cfg_index,
	input  logic [kcef_pkg::CFG_W-1:0]  cfg_data
);
	import kcef_pkg::*;

	kcef_qctl_t front_ctl;
	kcef_qctl_t back_ctl;
	kcef_item_t item;

	kcef_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.qctl_in  (back_ctl),
		.qctl_out (front_ctl),
		.item     (item)
	);

	kcef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qctl_in   (front_ctl),
		.qctl_out  (back_ctl),
		.item      (item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ hw/rtl/kcef_ram.sv @@
// ---------------------------------------------------------------------------
// kcef_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
module kcef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/kcef_front.sv @@
// ---------------------------------------------------------------------------
// kcef_front
// input side: takes beats, drops keys outside the matrix, queues the rest
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kcef_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [kcef_pkg::IN_TW-1:0] s_tdata,   // key_index[6:0], key_level[7], now_ms[39:8]
	input  kcef_pkg::kcef_qctl_t       qctl_in,
	output kcef_pkg::kcef_qctl_t       qctl_out,
	output kcef_pkg::kcef_item_t       item
);
	import kcef_pkg::*;

	kcef_item_t         fifo_q [QDEPTH];
	logic [QAW-1:0]     wptr_q;
	logic [QAW-1:0]     rptr_q;
	logic [QAW:0]       cnt_q;
	kcef_item_t         in_item;
	logic               in_range;
	logic               push;
	logic               pop;

	assign in_item  = kcef_item_t'(s_tdata);
	assign in_range = ({2'b00, in_item.key} < 9'(NKEYS));
	assign s_tready = (cnt_q != (QAW+1)'(QDEPTH));
	assign push     = s_tvalid && s_tready && in_range;
	assign pop      = qctl_in.pop;

	assign qctl_out.avail = (cnt_q != '0);
	assign qctl_out.pop   = pop;
	assign item           = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_bound, cnt_q > (QAW+1)'(QDEPTH))
	`ASSERT_NEVER(a_pop_empty, pop && (cnt_q == '0))
	`ASSERT_PROP(a_push_count, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

@@ hw/rtl/kcef_back.sv @@
// ---------------------------------------------------------------------------
// kcef_back
// per-key state machine: reads a key entry, updates it and emits events
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kcef_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [kcef_pkg::CFG_IW-1:0] cfg_index,
	input  logic [kcef_pkg::CFG_W-1:0]  cfg_data,
	input  kcef_pkg::kcef_qctl_t        qctl_in,
	output kcef_pkg::kcef_qctl_t        qctl_out,
	input  kcef_pkg::kcef_item_t        item,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [kcef_pkg::OUT_TW-1:0] m_tdata,   // event_key[6:0], held_ms[38:7]
	output logic [kcef_pkg::OUT_UW-1:0] m_tuser,   // event_kind[1:0]
	output logic                        m_tlast
);
	import kcef_pkg::*;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t             state_q;
	logic [15:0]        hold_q;
	logic [15:0]        double_q;
	logic [15:0]        long_q;
	logic               dbl_en_q;
	logic [NSLOTS-1:0]  vld_q;
	kcef_item_t         item_s1;
	logic               vld_s1;
	logic [1:0]         rem_q;
	logic [KEY_W-1:0]   key_q;
	kcef_event_t        cur_q;
	kcef_event_t        nxt_q;

	logic               start;
	logic               pop_beat;
	logic [KEY_AW-1:0]  raddr;
	logic [KEY_AW-1:0]  waddr;
	logic [$bits(kcef_entry_t)-1:0] rdata;
	kcef_entry_t        ent;
	kcef_entry_t        upd;

	logic [31:0]        t;
	logic [31:0]        dfp;
	logic [3:0]         fl;
	logic [1:0]         n;
	kcef_event_t        ev0;
	kcef_event_t        ev1;
	logic               on;

	assign start    = qctl_in.avail && (state_q == S_IDLE) && (rem_q == 2'd0);
	assign pop_beat = m_tvalid && m_tready;
	assign raddr    = item.key[KEY_AW-1:0];
	assign waddr    = item_s1.key[KEY_AW-1:0];

	assign qctl_out.avail = qctl_in.avail;
	assign qctl_out.pop   = start;

	kcef_ram #(
		.WIDTH ($bits(kcef_entry_t)),
		.DEPTH (NSLOTS)
	) u_ram (
		.clk   (clk),
		.we    (state_q == S_EXEC),
		.waddr (waddr),
		.wdata (upd),
		.re    (start),
		.raddr (raddr),
		.rdata (rdata)
	);

	// entries never written read as the reset value
	assign ent = vld_s1 ? kcef_entry_t'(rdata) : '0;
	assign on  = item_s1.level;
	assign t   = item_s1.now - ent.ps;
	assign dfp = item_s1.now - ent.fps;

	always_comb begin
		upd = ent;
		fl  = ent.flags;
		n   = 2'd0;
		ev0 = '0;
		ev1 = '0;
		unique case (ent.phase)
			PH_IDLE: begin
				if (on) begin
					fl[FL_PRESSED] = 1'b0;
					fl[FL_LONGREL] = 1'b0;
					upd.ps         = item_s1.now;
					if (dbl_en_q) begin
						if (ent.fps == '0) begin
							upd.fps       = item_s1.now;
							fl[FL_DOUBLE] = 1'b0;
						end else if (dfp < {16'd0, double_q}) begin
							ev0           = '{held: '0, kind: EV_DOUBLE};
							n             = 2'd1;
							fl[FL_DOUBLE] = 1'b1;
						end
					end
					upd.phase = PH_PRESSED;
				end else if (fl[FL_SHORT] && (t >= {16'd0, double_q})) begin
					ev0          = '{held: '0, kind: EV_PRESS};
					ev1          = '{held: t, kind: EV_RELEASE};
					n            = 2'd2;
					fl[FL_SHORT] = 1'b0;
					upd.fps      = '0;
				end
			end
			PH_PRESSED: begin
				if (!on) begin
					if (fl[FL_DOUBLE]) begin
						upd.fps   = '0;
						upd.phase = PH_RELEASED;
					end else begin
						upd.phase = PH_IDLE;
					end
				end else if (t >= {16'd0, hold_q}) begin
					upd.phase = PH_HOLD;
				end
			end
			PH_HOLD: begin
				if (!fl[FL_DOUBLE]) begin
					if (t >= {16'd0, long_q}) begin
						if (!fl[FL_LONGREL]) begin
							ev0            = '{held: t, kind: EV_LONGREL};
							n              = 2'd1;
							fl[FL_LONGREL] = 1'b1;
						end
					end else if (t >= {16'd0, double_q}) begin
						if (!fl[FL_PRESSED]) begin
							ev0            = '{held: '0, kind: EV_PRESS};
							n              = 2'd1;
							fl[FL_PRESSED] = 1'b1;
						end
					end
					if (!on) begin
						if (!fl[FL_PRESSED]) begin
							fl[FL_SHORT] = 1'b1;
							upd.phase    = PH_IDLE;
						end else begin
							upd.phase = PH_RELEASED;
						end
					end
				end else if (!on) begin
					fl[FL_SHORT] = 1'b0;
					upd.fps      = '0;
					upd.phase    = PH_RELEASED;
				end
			end
			PH_RELEASED: begin
				if (!fl[FL_LONGREL]) begin
					ev0 = '{held: t, kind: EV_RELEASE};
					n   = 2'd1;
				end
				upd.phase = PH_IDLE;
			end
		endcase
		upd.flags = fl;
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tlast  = (rem_q == 2'd1);
	assign m_tdata  = {1'b0, cur_q.held, key_q};
	assign m_tuser  = cur_q.kind;

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hold_q   <= HOLD_RST;
			double_q <= DOUBLE_RST;
			long_q   <= LONG_RST;
			dbl_en_q <= 1'b0;
			vld_q    <= '0;
			vld_s1   <= 1'b0;
			rem_q    <= 2'd0;
			key_q    <= '0;
			cur_q    <= '0;
			nxt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HOLD:   hold_q   <= cfg_data;
					CFG_DOUBLE: double_q <= cfg_data;
					CFG_LONG:   long_q   <= cfg_data;
					CFG_DBL_EN: dbl_en_q <= cfg_data[0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						vld_s1  <= vld_q[raddr];
						state_q <= S_EXEC;
					end
					if (pop_beat) begin
						cur_q <= nxt_q;
						rem_q <= rem_q - 2'd1;
					end
				end
				S_EXEC: begin
					vld_q[waddr] <= 1'b1;
					key_q        <= item_s1.key;
					cur_q        <= ev0;
					nxt_q        <= ev1;
					rem_q        <= n;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_PROP(a_exec_one, (state_q == S_EXEC) |=> (state_q == S_IDLE))
	`ASSERT_NEVER(a_load_busy, (state_q == S_EXEC) && (rem_q != 2'd0))
	`ASSERT_NEVER(a_rem_range, rem_q == 2'd3)
	`ASSERT_PROP(a_start_exec, start |=> (state_q == S_EXEC))

endmodule
